>>> rtl/core/bti_pkg.sv
package bti_pkg;

    localparam int MAX_COLS_DEF   = 16;
    localparam int MAX_ROWS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        CMD_LOAD_COL  = 2'd0,
        CMD_LOAD_ROW  = 2'd1,
        CMD_LOAD_GRID = 2'd2,
        CMD_QUERY     = 2'd3
    } t_cmd;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         col_index;
        logic [3:0]         row_index;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CX0,
        ST_CSCAN,
        ST_RX0,
        ST_RSCAN,
        ST_PTS,
        ST_PTS_W,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_G3_W,
        ST_L_SETUP,
        ST_L_MUL,
        ST_L_DIV,
        ST_L_DONE,
        ST_OUT
    } t_state;

endpackage

>>> rtl/core/bilinear_table_interpolator.sv
// Channel | Direction | Handshake                 | Word
// in      | input     | i_valid / o_stall         | t_in_word: cmd, indexes, load and query values
// out     | output    | o_valid / i_stall         | t_out_word: value, status
// cfg     | input     | i_cfg_valid / o_cfg_ready | index 0 cols_in_use, 1 rows_in_use
// Loads are taken only while idle and follow back to back.
// A query keeps o_stall high through the column search, the row search in 2D mode,
// the table reads, the 1D steps (one in 1D, three in 2D; a trivial step skips the
// divide) and the output state.
// A query outside the domain ends right after its search.
// Reset clears control state only; tables are undefined until loaded.
// The result waits in the output register; the output state holds until it is free.
module bilinear_table_interpolator
    import bti_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int GD  = MAX_ROWS * MAX_COLS;
    localparam int GW  = $clog2(GD);
    localparam int NW  = 10;
    localparam int WB  = 66;   // wide signed difference
    localparam int DB  = 32;   // divisor and operand magnitude width
    localparam int PB  = 64;   // product width
    localparam int BW  = $clog2(PB);
    localparam logic signed [WB-1:0] SAT_HI = (WB'(1) <<< (VALUE_BITS-1)) - WB'(1);
    localparam logic signed [WB-1:0] SAT_LO = -SAT_HI - WB'(1);

    // memories
    logic signed [31:0] m_col  [MAX_COLS];
    logic signed [31:0] m_row  [MAX_ROWS];
    logic signed [31:0] m_grid [GD];
    logic [CW-1:0] col_ra;
    logic [RW-1:0] row_ra;
    logic [GW-1:0] grid_ra;
    logic signed [31:0] col_rd, row_rd, grid_rd;

    logic [4:0] r_cols, r_rows;
    t_state     r_state, n_state;
    t_in_word   r_q;
    logic [NW-1:0] r_k, r_idx, nc, nr;
    logic r_found, r_oob;
    logic signed [31:0] r_first;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    logic signed [31:0] r_xa, r_xb, r_ya, r_yb, r_g [4];
    logic [1:0] r_gi;
    logic signed [WB-1:0] r_row1, r_row2;
    logic [1:0] r_step;   // 0 row1, 1 row2, 2 final
    logic signed [WB-1:0] r_lq, r_lx0, r_lx1, r_ly0, r_ly1;
    logic [DB-1:0] r_dx;
    logic r_neg, r_trivial;
    logic [PB-1:0] r_prod;
    logic [DB:0] r_rem;
    logic [PB-1:0] r_quo;
    logic [BW-1:0] r_bit;
    logic signed [WB-1:0] r_res;
    logic r_oval;
    t_out_word r_out;
    logic in_acc, out_take, is_query;

    // search compare
    logic signed [31:0] scan_rd, scan_q, scan_first;
    logic [NW-1:0] scan_n, scan_pick, scan_idx;
    logic scan_hit, scan_last, scan_oob;

    // 1D step operands
    logic signed [WB-1:0] l_dx, l_dq, l_dy;
    logic [DB-1:0] l_mag;
    logic l_triv;

    assign nc = (r_cols < 5'd2) ? NW'(2) :
                (NW'(r_cols) > NW'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(r_cols);
    assign nr = (r_rows < 5'd1) ? NW'(1) :
                (NW'(r_rows) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(r_rows);

    assign out_take    = r_oval && !i_stall;
    assign in_acc      = i_valid && !o_stall;
    assign is_query    = i_data.cmd == CMD_QUERY;
    assign o_valid     = r_oval;
    assign o_data      = r_out;

    // handshake outputs
    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
    end

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (in_acc && i_data.cmd == CMD_LOAD_COL && 32'(i_data.col_index) < MAX_COLS)
            m_col[CW'(i_data.col_index)] <= i_data.load_value;
        if (in_acc && i_data.cmd == CMD_LOAD_ROW && 32'(i_data.row_index) < MAX_ROWS)
            m_row[RW'(i_data.row_index)] <= i_data.load_value;
        if (in_acc && i_data.cmd == CMD_LOAD_GRID && 32'(i_data.col_index) < MAX_COLS
            && 32'(i_data.row_index) < MAX_ROWS)
            m_grid[GW'(32'(i_data.row_index) * MAX_COLS + 32'(i_data.col_index))]
                <= i_data.load_value;
        col_rd  <= m_col[col_ra];
        row_rd  <= m_row[row_ra];
        grid_rd <= m_grid[grid_ra];
    end

    // read addresses
    always_comb begin
        col_ra  = CW'(r_k);
        row_ra  = RW'(r_k);
        grid_ra = '0;
        if (r_state == ST_PTS) begin
            col_ra = r_c - CW'(1);
            row_ra = r_r - RW'(1);
        end else if (r_state == ST_PTS_W) begin
            col_ra = r_c;
            row_ra = r_r;
        end
        unique case (r_gi)
            2'd0: grid_ra = GW'((32'(r_r) - 32'd1) * MAX_COLS + 32'(r_c) - 32'd1);
            2'd1: grid_ra = GW'((32'(r_r) - 32'd1) * MAX_COLS + 32'(r_c));
            2'd2: grid_ra = GW'(32'(r_r) * MAX_COLS + 32'(r_c) - 32'd1);
            default: grid_ra = GW'(32'(r_r) * MAX_COLS + 32'(r_c));
        endcase
    end

    // upper-bound search: the read data holds entry r_k-1
    always_comb begin
        if (r_state == ST_RSCAN) begin
            scan_rd = row_rd;
            scan_q  = r_q.query_y;
            scan_n  = nr;
        end else begin
            scan_rd = col_rd;
            scan_q  = r_q.query_x;
            scan_n  = nc;
        end
        scan_hit = !r_found && (scan_rd > scan_q);
        if (r_found)       scan_pick = r_idx;
        else if (scan_hit) scan_pick = r_k - NW'(1);
        else               scan_pick = scan_n - NW'(1);
        scan_idx   = (scan_pick == '0) ? NW'(1) : scan_pick;
        scan_first = (r_k == NW'(1)) ? scan_rd : r_first;
        // out of domain below the first or above the last breakpoint
        scan_oob   = (scan_q < scan_first) || (scan_q > scan_rd);
        scan_last  = (r_k == scan_n);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && is_query) n_state = ST_CX0;
            ST_CX0:   n_state = ST_CSCAN;
            ST_CSCAN: if (scan_last) begin
                if (scan_oob)             n_state = ST_OUT;
                else if (nr == NW'(1))    n_state = ST_PTS;
                else                      n_state = ST_RX0;
            end
            ST_RX0:   n_state = ST_RSCAN;
            ST_RSCAN: if (scan_last) n_state = scan_oob ? ST_OUT : ST_PTS;
            ST_PTS:   n_state = ST_PTS_W;
            ST_PTS_W: n_state = ST_G0;
            ST_G0:    n_state = ST_G1;
            ST_G1:    n_state = ST_G2;
            ST_G2:    n_state = ST_G3;
            ST_G3:    n_state = ST_G3_W;
            ST_G3_W:  n_state = ST_L_SETUP;
            ST_L_SETUP: n_state = ST_L_MUL;
            ST_L_MUL: n_state = l_triv ? ST_L_DONE : ST_L_DIV;
            ST_L_DIV: if (r_bit == '0) n_state = ST_L_DONE;
            ST_L_DONE: n_state = (r_step == 2'd2 || (nr == NW'(1) && r_step == 2'd0))
                                 ? ST_OUT : ST_L_SETUP;
            ST_OUT:   if (!r_oval || out_take) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath
    logic [DB:0] rem_sh;
    logic signed [WB-1:0] part_s, lres;
    assign l_dx   = r_lx1 - r_lx0;
    assign l_dq   = r_lq - r_lx0;
    assign l_dy   = r_ly1 - r_ly0;
    assign l_mag  = l_dy[WB-1] ? DB'(-l_dy) : DB'(l_dy);
    // zero-width or reversed interval, or query at or below the lower end, gives y0
    assign l_triv = l_dx[WB-1] || (l_dx == '0) || l_dq[WB-1] || (l_dq == '0);
    assign rem_sh = {r_rem[DB-1:0], r_prod[r_bit]};
    assign part_s = $signed(WB'(r_quo));
    always_comb begin
        lres = r_trivial ? r_ly0 : (r_neg ? r_ly0 - part_s : r_ly0 + part_s);
        if (lres > SAT_HI) lres = SAT_HI;
        else if (lres < SAT_LO) lres = SAT_LO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cols  <= 5'd2;
            r_rows  <= 5'd1;
            r_oval  <= 1'b0;
            r_k     <= '0;
            r_gi    <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_oob   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_COLS) r_cols <= i_cfg_data;
                else                          r_rows <= i_cfg_data;
            end
            if (r_state == ST_OUT && (!r_oval || out_take)) r_oval <= 1'b1;
            else if (out_take)                               r_oval <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    r_step <= '0;
                    r_oob <= 1'b0;
                    if (in_acc && is_query) r_q <= i_data;
                end
                ST_CX0: begin
                    r_k <= NW'(1);
                    r_found <= 1'b0;
                end
                ST_CSCAN, ST_RSCAN: begin
                    if (r_k == NW'(1)) r_first <= scan_rd;
                    if (scan_hit) r_idx <= r_k - NW'(1);
                    r_found <= !scan_last && (r_found || scan_hit);
                    if (!scan_last) r_k <= r_k + NW'(1);
                    else begin
                        r_k   <= '0;
                        r_oob <= scan_oob;
                        r_res <= '0;
                        if (r_state == ST_CSCAN) begin
                            r_c <= CW'(scan_idx);
                            r_r <= RW'(1);
                        end else begin
                            r_r <= RW'(scan_idx);
                        end
                    end
                end
                ST_RX0:   r_k <= NW'(1);
                ST_PTS:   r_gi <= '0;
                ST_PTS_W: begin
                    r_xa <= col_rd;
                    r_ya <= row_rd;
                end
                ST_G0: begin
                    r_xb <= col_rd;
                    r_yb <= row_rd;
                    r_gi <= 2'd1;
                end
                ST_G1: begin
                    r_g[0] <= grid_rd;
                    r_gi <= 2'd2;
                end
                ST_G2: begin
                    r_g[1] <= grid_rd;
                    r_gi <= 2'd3;
                end
                ST_G3:   r_g[2] <= grid_rd;
                ST_G3_W: r_g[3] <= grid_rd;
                ST_L_SETUP: begin
                    if (r_step == 2'd2) begin
                        r_lq <= WB'(r_q.query_y); r_lx0 <= WB'(r_ya); r_lx1 <= WB'(r_yb);
                        r_ly0 <= r_row1;          r_ly1 <= r_row2;
                    end else begin
                        r_lq <= WB'(r_q.query_x); r_lx0 <= WB'(r_xa); r_lx1 <= WB'(r_xb);
                        r_ly0 <= WB'(r_step[0] ? r_g[2] : r_g[0]);
                        r_ly1 <= WB'(r_step[0] ? r_g[3] : r_g[1]);
                    end
                end
                ST_L_MUL: begin
                    // inside the interval both |dy| and dq fit in 32 bits
                    r_dx      <= l_dx[DB-1:0];
                    r_neg     <= l_dy[WB-1];
                    r_trivial <= l_triv;
                    r_prod    <= {{(PB-DB){1'b0}}, l_mag} * {{(PB-DB){1'b0}}, l_dq[DB-1:0]};
                    r_rem     <= '0;
                    r_quo     <= '0;
                    r_bit     <= BW'(PB - 1);
                end
                ST_L_DIV: begin
                    if (rem_sh >= {1'b0, r_dx}) begin
                        r_rem <= rem_sh - {1'b0, r_dx};
                        r_quo <= {r_quo[PB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[PB-2:0], 1'b0};
                    end
                    r_bit <= r_bit - BW'(1);
                end
                ST_L_DONE: begin
                    if (r_step == 2'd0) r_row1 <= lres;
                    if (r_step == 2'd1) r_row2 <= lres;
                    r_res <= lres;
                    r_step <= r_step + 2'd1;
                end
                ST_OUT: if (!r_oval || out_take) begin
                    r_out.value  <= r_res[31:0];
                    r_out.status <= r_oob;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("word accepted while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && i_stall) |=> r_oval && $stable(r_out))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_L_DIV) |-> r_dx != '0)
        else $error("divide by zero");
endmodule

>>> dv/tb_bilinear_table_interpolator.sv
`timescale 1ns / 100ps

module tb_bilinear_table_interpolator;
    import bti_pkg::*;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int     NPHASE = 9;
    localparam int     SETTLE = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_word   i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_word  o_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_COLS;
    logic [4:0] i_cfg_data = '0;

    bilinear_table_interpolator uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // words waiting to go in, results still owed
    t_in_word  pending_words[$];
    t_out_word owed_results[$];
    int        errors = 0;
    int        queries_sent = 0;
    int        loads_sent = 0;
    int        outside_hits = 0;
    bit        steady = 1'b0;

    // predictor copy of the tables and registers
    longint    col_tab[16];
    longint    row_tab[16];
    longint    grid_tab[256];
    logic [4:0] cols_reg = 5'd2;
    logic [4:0] rows_reg = 5'd1;

    // stimulus-side copy of what has been loaded
    longint    plan_col[16];
    longint    plan_row[16];

    function automatic longint clip32(logic signed [127:0] v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return longint'(v);
    endfunction

    // one linear step, exact quotient truncated toward zero
    function automatic longint lerp_step(longint q, longint x0, longint x1,
                                         longint y0, longint y1);
        logic signed [127:0] dx, dq, dy, mag, part;
        dx = x1 - x0;
        dq = q - x0;
        dy = y1 - y0;
        if (dx <= 0 || dq <= 0) return clip32(y0);
        mag  = (dy < 0) ? -dy : dy;
        part = (mag * dq) / dx;
        return clip32((dy < 0) ? (y0 - part) : (y0 + part));
    endfunction

    // upper-bound search; 0 means out of domain, else the upper interval end
    function automatic int upper_index(bit is_row, int n, longint q);
        int i;
        longint p;
        i = n;
        if (q < (is_row ? row_tab[0] : col_tab[0])) return 0;
        if (q > (is_row ? row_tab[n-1] : col_tab[n-1])) return 0;
        for (int k = 0; k < n; k++) begin
            p = is_row ? row_tab[k] : col_tab[k];
            if (p > q) begin
                i = k;
                break;
            end
        end
        if (i >= n) i = n - 1;
        if (i < 1) i = 1;
        return i;
    endfunction

    function automatic longint along_row(int r, int c, longint qx);
        return lerp_step(qx, col_tab[c-1], col_tab[c],
                         grid_tab[r*16 + c - 1], grid_tab[r*16 + c]);
    endfunction

    // apply one accepted word to the predictor
    task automatic predict_word(t_in_word w);
        t_out_word res;
        int nc, nr, c, r;
        longint qx, qy, a, b;
        qx = longint'(w.query_x);
        qy = longint'(w.query_y);
        case (t_cmd'(w.cmd))
            CMD_LOAD_COL:  col_tab[w.col_index] = longint'(w.load_value);
            CMD_LOAD_ROW:  row_tab[w.row_index] = longint'(w.load_value);
            CMD_LOAD_GRID: grid_tab[{w.row_index, w.col_index}] = longint'(w.load_value);
            default: begin
                nc = (cols_reg < 2) ? 2 : ((cols_reg > 16) ? 16 : int'(cols_reg));
                nr = (rows_reg < 1) ? 1 : ((rows_reg > 16) ? 16 : int'(rows_reg));
                res = '{value: '0, status: 1'b1};
                c = upper_index(1'b0, nc, qx);
                if (c != 0) begin
                    if (nr == 1) begin
                        res = '{value: 32'(along_row(0, c, qx)), status: 1'b0};
                    end else begin
                        r = upper_index(1'b1, nr, qy);
                        if (r != 0) begin
                            a = along_row(r - 1, c, qx);
                            b = along_row(r, c, qx);
                            res = '{value: 32'(lerp_step(qy, row_tab[r-1], row_tab[r], a, b)),
                                    status: 1'b0};
                        end
                    end
                end
                if (res.status) outside_hits++;
                owed_results = {owed_results, res};
            end
        endcase
    endtask

    // input driver: holds a stalled word, idles at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_word(i_data);
            if (!i_valid || !o_stall) begin
                if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
                    i_valid <= 1'b1;
                    i_data  <= pending_words.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each accepted word, stalls at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result word with nothing owed: value %0d status %0d",
                           o_data.value, o_data.status);
                    errors++;
                end else begin
                    t_out_word want;
                    want = owed_results.pop_front();
                    if (o_data.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, o_data.value);
                        errors++;
                    end
                    if (o_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_data.status);
                        errors++;
                    end
                end
            end
            i_stall <= !steady && ($urandom_range(99) < 38);
        end
    end

    task automatic push_load(t_cmd cmd, int ci, int ri, longint v);
        t_in_word w;
        w = '{cmd: cmd, col_index: 4'(ci), row_index: 4'(ri), load_value: 32'(v),
              query_x: $urandom, query_y: $urandom};
        pending_words = {pending_words, w};
        loads_sent++;
    endtask

    task automatic push_query(longint x, longint y);
        t_in_word w;
        w = '{cmd: CMD_QUERY, col_index: 4'($urandom), row_index: 4'($urandom),
              load_value: $urandom, query_x: 32'(x), query_y: 32'(y)};
        pending_words = {pending_words, w};
        queries_sent++;
    endtask

    // build and load one axis of breakpoints; style picks the shape
    task automatic load_axis(bit is_row, int n, int style);
        longint v, stepmax, pts[16];
        v = longint'($signed($urandom_range(32'h7FFF_FFFF))) - 64'sd1073741824;
        stepmax = (SMAX - v) / 17;
        if (style == 3 || $urandom_range(3) == 0) stepmax = 64'd200;
        for (int k = 0; k < 16; k++) begin
            pts[k] = v;
            if (style == 1 && $urandom_range(2) == 0) v = v;
            else v = v + longint'($urandom_range(32'(stepmax)));
        end
        if (style == 2) begin
            // span the whole signed range across the entries in use
            for (int k = 0; k < 16; k++)
                pts[k] = (k >= n - 1) ? SMAX : SMIN + (longint'(k) * 64'd4294967295) / (n - 1);
        end
        if (style == 3) begin
            for (int k = 0; k < 16; k++)
                pts[k] = longint'($signed($urandom_range(32'hFFFF, 0))) - 64'sd32768;
        end
        for (int k = 0; k < 16; k++) begin
            if (is_row) plan_row[k] = pts[k];
            else plan_col[k] = pts[k];
            push_load(is_row ? CMD_LOAD_ROW : CMD_LOAD_COL, is_row ? $urandom : k,
                      is_row ? k : $urandom, pts[k]);
        end
    endtask

    // a coordinate mostly inside the domain, sometimes on or past its edges
    function automatic longint pick_coord(bit is_row, int n);
        longint a, b, lo, hi, t;
        int sel, k;
        longint unsigned span;
        lo = is_row ? plan_row[0] : plan_col[0];
        hi = is_row ? plan_row[n-1] : plan_col[n-1];
        sel = $urandom_range(99);
        if (sel < 66) begin
            k = $urandom_range(n - 2);
            a = is_row ? plan_row[k] : plan_col[k];
            b = is_row ? plan_row[k+1] : plan_col[k+1];
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            span = longint'(b - a) + 1;
            return a + longint'({$urandom, $urandom} % span);
        end
        if (sel < 80) begin
            k = $urandom_range(n - 1);
            return is_row ? plan_row[k] : plan_col[k];
        end
        if (sel < 90) begin
            if ($urandom_range(1) && lo > SMIN) return lo - 1 - $urandom_range(1000);
            if (hi < SMAX) return hi + 1 + $urandom_range(1000);
            return SMIN;
        end
        return longint'($signed($urandom));
    endfunction

    task automatic write_reg(logic idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_COLS) cols_reg = val;
        else rows_reg = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // column and row counts per phase; out-of-range values check clamping
    int cols_set[NPHASE] = '{2, 16, 4, 0, 31, 9, 5, 16, 3};
    int rows_set[NPHASE] = '{1, 16, 3, 0, 31, 1, 16, 2, 5};
    int style_set[NPHASE] = '{0, 2, 1, 0, 3, 0, 1, 0, 3};

    initial begin
        int nc, nr, g;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every table entry before any query
        load_axis(1'b0, 2, 0);
        load_axis(1'b1, 2, 0);
        for (int k = 0; k < 256; k++) push_load(CMD_LOAD_GRID, k % 16, k / 16, $signed($urandom));
        push_load(CMD_LOAD_GRID, 0, 0, SMIN);
        push_load(CMD_LOAD_GRID, 1, 0, SMAX);

        // directed: edges of the domain and extreme coordinates at reset setting
        push_query(plan_col[0], SMIN);
        push_query(plan_col[1], SMAX);
        push_query(plan_col[0] - 1, 0);
        push_query(plan_col[1] + 1, 0);
        push_query(SMIN, 0);
        push_query(SMAX, -1);
        push_query((plan_col[0] + plan_col[1]) / 2, 0);
        drain();

        for (int ph = 0; ph < NPHASE; ph++) begin
            steady = (ph == 6);
            write_reg(CFG_COLS, 5'(cols_set[ph]));
            write_reg(CFG_ROWS, 5'(rows_set[ph]));
            nc = (cols_set[ph] < 2) ? 2 : ((cols_set[ph] > 16) ? 16 : cols_set[ph]);
            nr = (rows_set[ph] < 1) ? 1 : ((rows_set[ph] > 16) ? 16 : rows_set[ph]);
            load_axis(1'b0, nc, style_set[ph]);
            load_axis(1'b1, nr, style_set[ph]);
            for (int k = 0; k < 24; k++) begin
                g = $urandom_range(255);
                push_load(CMD_LOAD_GRID, g % 16, g / 16,
                          ($urandom_range(7) == 0) ? (($urandom_range(1)) ? SMAX : SMIN)
                                                   : longint'($signed($urandom)));
            end
            // queries in batches of 40, each batch followed by one grid load
            for (int k = 0; k < 120; k++) begin
                push_query(pick_coord(1'b0, nc),
                           (nr == 1) ? longint'($signed($urandom)) : pick_coord(1'b1, nr));
                if (k % 40 == 39) begin
                    g = $urandom_range(255);
                    push_load(CMD_LOAD_GRID, g % 16, g / 16, $signed($urandom));
                end
            end
            drain();
        end

        $display("covered %0d queries (%0d outside the domain) and %0d loads",
                 queries_sent, outside_hits, loads_sent);
        $display("over %0d register settings, clamped counts included", NPHASE + 1);
        if (errors == 0) begin
            $display("bilinear_table_interpolator test passed");
        end else begin
            $display("bilinear_table_interpolator test failed");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #200ms;
        $display("bilinear_table_interpolator test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bti_pkg.sv
rtl/core/bilinear_table_interpolator.sv
dv/tb_bilinear_table_interpolator.sv
